// ===== hw/rtl/dwc_pkg.sv =====
// ----------------------------------------------------------------------------
// dwc_pkg: shared types and constants for the depthwise 3x3 convolution
// Binary32 type, default NaN pattern, register map and float compare.
// ----------------------------------------------------------------------------
`default_nettype none

package dwc_pkg;

    typedef logic [31:0] fp32_t;

    localparam fp32_t FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam fp32_t FP_QUIET_BIT   = 32'h0040_0000;

    typedef enum logic [2:0] {
        CFG_BIAS_K00 = 3'd0,
        CFG_K01_K02  = 3'd1,
        CFG_K10_K11  = 3'd2,
        CFG_K12_K20  = 3'd3,
        CFG_K21_K22  = 3'd4,
        CFG_CLAMP    = 3'd5
    } cfg_idx_t;

    function automatic logic fp_is_nan(input fp32_t v);
        fp_is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    // Ordered a < b; false when either side is NaN
    function automatic logic fp_lt(input fp32_t a, input fp32_t b);
        logic res;
        res = 1'b0;
        if (fp_is_nan(a) || fp_is_nan(b))
        begin
            res = 1'b0;
        end
        else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
        begin
            res = 1'b0;
        end
        else if (a[31] && !b[31])
        begin
            res = 1'b1;
        end
        else if (!a[31] && b[31])
        begin
            res = 1'b0;
        end
        else if (!a[31])
        begin
            res = (a[30:0] < b[30:0]);
        end
        else
        begin
            res = (a[30:0] > b[30:0]);
        end
        fp_lt = res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dwc_fmul.sv =====
// ----------------------------------------------------------------------------
// dwc_fmul: binary32 multiplier, two stages
// Stage one forms the significand product, stage two normalizes and rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module dwc_fmul (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire dwc_pkg::fp32_t a,
    input  wire dwc_pkg::fp32_t b,
    output dwc_pkg::fp32_t      y
);
    import dwc_pkg::*;

    logic              sgn;
    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic              spec;
    fp32_t             spec_val;
    logic [23:0]       ma, mb;
    logic [7:0]        ea, eb;

    logic              sgn_reg;
    logic              spec_reg;
    fp32_t             spec_val_reg;
    logic [47:0]       prod_reg;
    logic signed [10:0] e_reg;

    logic [5:0]        lz;
    logic [47:0]       norm;
    logic signed [10:0] e_b;
    logic [5:0]        sh;
    logic [7:0]        field;
    logic [95:0]       shifted;
    logic [47:0]       kept;
    logic [23:0]       mant;
    logic              guard, sticky, inc;
    logic [30:0]       res;
    fp32_t             y_reg;

    always_comb
    begin
        sgn    = a[31] ^ b[31];
        a_nan  = fp_is_nan(a);
        b_nan  = fp_is_nan(b);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        spec   = 1'b1;
        if (a_nan)
        begin
            spec_val = a | FP_QUIET_BIT;
        end
        else if (b_nan)
        begin
            spec_val = b | FP_QUIET_BIT;
        end
        else if ((a_inf && b_zero) || (a_zero && b_inf))
        begin
            spec_val = FP_DEFAULT_NAN;
        end
        else if (a_inf || b_inf)
        begin
            spec_val = {sgn, 8'hFF, 23'd0};
        end
        else if (a_zero || b_zero)
        begin
            spec_val = {sgn, 31'd0};
        end
        else
        begin
            spec     = 1'b0;
            spec_val = {sgn, 31'd0};
        end
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgn_reg      <= sgn;
            spec_reg     <= spec;
            spec_val_reg <= spec_val;
            prod_reg     <= ma * mb;
            e_reg        <= $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
        end
    end

    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (prod_reg[i])
            begin
                lz = 6'(47 - i);
            end
        end
        norm = prod_reg << lz;
        e_b  = e_reg - $signed({5'b00000, lz});
        if (e_b <= 11'sd0)
        begin
            field = 8'd0;
            sh    = (e_b < -11'sd62) ? 6'd63 : 6'(11'sd1 - e_b);
        end
        else
        begin
            field = e_b[7:0];
            sh    = 6'd0;
        end
        shifted = {norm, 48'd0} >> sh;
        kept    = shifted[95:48];
        mant    = kept[47:24];
        guard   = kept[23];
        sticky  = (|kept[22:0]) | (|shifted[47:0]);
        inc     = guard & (sticky | mant[0]);
        res     = {field, mant[22:0]} + {30'd0, inc};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (spec_reg)
            begin
                y_reg <= spec_val_reg;
            end
            else if (e_b >= 11'sd255)
            begin
                y_reg <= {sgn_reg, 8'hFF, 23'd0};
            end
            else
            begin
                y_reg <= {sgn_reg, res};
            end
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dwc_fadd.sv =====
// ----------------------------------------------------------------------------
// dwc_fadd: binary32 adder, two stages
// Stage one aligns and adds, stage two normalizes and rounds to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

module dwc_fadd (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire dwc_pkg::fp32_t a,
    input  wire dwc_pkg::fp32_t b,
    output dwc_pkg::fp32_t      y
);
    import dwc_pkg::*;

    logic        a_inf, b_inf;
    logic        spec;
    fp32_t       spec_val;
    logic        swap;
    fp32_t       big, small_op;
    logic [7:0]  e_big, e_small, d;
    logic [4:0]  dc;
    logic [26:0] m_big;
    logic [53:0] al;
    logic [26:0] m_small;
    logic        sub;
    logic [27:0] sum;

    logic        spec_reg;
    fp32_t       spec_val_reg;
    logic [27:0] sum_reg;
    logic [7:0]  e_reg;
    logic        sgn_reg;
    logic        sub_reg;

    logic [4:0]  lz;
    logic [4:0]  shl;
    logic [7:0]  lim;
    logic [26:0] r27;
    logic [8:0]  e_n;
    logic [7:0]  field;
    logic        guard, sticky, inc;
    logic [30:0] res;
    fp32_t       y_reg;

    always_comb
    begin
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        spec  = 1'b1;
        if (fp_is_nan(a))
        begin
            spec_val = a | FP_QUIET_BIT;
        end
        else if (fp_is_nan(b))
        begin
            spec_val = b | FP_QUIET_BIT;
        end
        else if (a_inf && b_inf && (a[31] != b[31]))
        begin
            spec_val = FP_DEFAULT_NAN;
        end
        else if (a_inf)
        begin
            spec_val = a;
        end
        else if (b_inf)
        begin
            spec_val = b;
        end
        else
        begin
            spec     = 1'b0;
            spec_val = a;
        end
        swap     = (a[30:0] < b[30:0]);
        big      = swap ? b : a;
        small_op = swap ? a : b;
        e_big    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_small  = (small_op[30:23] == 8'd0) ? 8'd1 : small_op[30:23];
        d        = e_big - e_small;
        dc       = (d > 8'd31) ? 5'd31 : d[4:0];
        m_big    = {(big[30:23] != 8'd0), big[22:0], 3'b000};
        al       = {(small_op[30:23] != 8'd0), small_op[22:0], 3'b000, 27'd0} >> dc;
        m_small  = {al[53:28], al[27] | (|al[26:0])};
        sub      = a[31] ^ b[31];
        sum      = sub ? ({1'b0, m_big} - {1'b0, m_small})
                       : ({1'b0, m_big} + {1'b0, m_small});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spec_reg     <= spec;
            spec_val_reg <= spec_val;
            sum_reg      <= sum;
            e_reg        <= e_big;
            sgn_reg      <= big[31];
            sub_reg      <= sub;
        end
    end

    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 27; i++)
        begin
            if (sum_reg[i])
            begin
                lz = 5'(26 - i);
            end
        end
        lim = e_reg - 8'd1;
        shl = ({3'b000, lz} > lim) ? lim[4:0] : lz;
        if (sum_reg[27])
        begin
            r27 = {sum_reg[27:2], sum_reg[1] | sum_reg[0]};
            e_n = {1'b0, e_reg} + 9'd1;
        end
        else
        begin
            r27 = sum_reg[26:0] << shl;
            e_n = {1'b0, e_reg} - {4'd0, shl};
        end
        field  = r27[26] ? e_n[7:0] : 8'd0;
        guard  = r27[2];
        sticky = r27[1] | r27[0];
        inc    = guard & (sticky | r27[3]);
        res    = {field, r27[25:3]} + {30'd0, inc};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (spec_reg)
            begin
                y_reg <= spec_val_reg;
            end
            else if (sum_reg == 28'd0)
            begin
                y_reg <= {sgn_reg & ~sub_reg, 31'd0};
            end
            else if (e_n >= 9'd255)
            begin
                y_reg <= {sgn_reg, 8'hFF, 23'd0};
            end
            else
            begin
                y_reg <= {sgn_reg, res};
            end
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dwc_lane.sv =====
// ----------------------------------------------------------------------------
// dwc_lane: one kernel row
// Three products in parallel, then centre, right and left taps summed in order.
// ----------------------------------------------------------------------------
`default_nettype none

module dwc_lane (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic           has_start,
    input  wire dwc_pkg::fp32_t start,
    input  wire dwc_pkg::fp32_t ev,
    input  wire dwc_pkg::fp32_t od,
    input  wire dwc_pkg::fp32_t lt,
    input  wire dwc_pkg::fp32_t kl,
    input  wire dwc_pkg::fp32_t kc,
    input  wire dwc_pkg::fp32_t kr,
    output dwc_pkg::fp32_t      row_sum
);
    import dwc_pkg::*;

    fp32_t p1, p2, p3;
    fp32_t add1_y, acc1, acc2;
    fp32_t p1_d_reg [2];
    fp32_t p2_d_reg [2];
    fp32_t p3_d_reg [4];

    dwc_fmul u_mul_c (.clk(clk), .en(en), .a(ev), .b(kc), .y(p1));
    dwc_fmul u_mul_r (.clk(clk), .en(en), .a(od), .b(kr), .y(p2));
    dwc_fmul u_mul_l (.clk(clk), .en(en), .a(lt), .b(kl), .y(p3));

    // Line up the later products with the running sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_d_reg[0] <= p1;
            p1_d_reg[1] <= p1_d_reg[0];
            p2_d_reg[0] <= p2;
            p2_d_reg[1] <= p2_d_reg[0];
            p3_d_reg[0] <= p3;
            for (int i = 1; i < 4; i++)
            begin
                p3_d_reg[i] <= p3_d_reg[i - 1];
            end
        end
    end

    dwc_fadd u_add_s (.clk(clk), .en(en), .a(start), .b(p1), .y(add1_y));

    assign acc1 = has_start ? add1_y : p1_d_reg[1];

    dwc_fadd u_add_r (.clk(clk), .en(en), .a(acc1), .b(p2_d_reg[1]), .y(acc2));
    dwc_fadd u_add_l (.clk(clk), .en(en), .a(acc2), .b(p3_d_reg[3]), .y(row_sum));

endmodule

`default_nettype wire

// ===== hw/rtl/dwc_merge.sv =====
// ----------------------------------------------------------------------------
// dwc_merge: combine the three row sums and clamp
// (top + mid) + bot, then max against the lower and min against the upper bound.
// ----------------------------------------------------------------------------
`default_nettype none

module dwc_merge (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire dwc_pkg::fp32_t top,
    input  wire dwc_pkg::fp32_t mid,
    input  wire dwc_pkg::fp32_t bot,
    input  wire dwc_pkg::fp32_t lo,
    input  wire dwc_pkg::fp32_t hi,
    output dwc_pkg::fp32_t      clamped
);
    import dwc_pkg::*;

    fp32_t tm, total, r;
    fp32_t bot_d_reg [2];

    dwc_fadd u_add_tm (.clk(clk), .en(en), .a(top), .b(mid), .y(tm));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bot_d_reg[0] <= bot;
            bot_d_reg[1] <= bot_d_reg[0];
        end
    end

    dwc_fadd u_add_b (.clk(clk), .en(en), .a(tm), .b(bot_d_reg[1]), .y(total));

    // A NaN sum fails the compare and takes the lower bound
    always_comb
    begin
        r       = fp_lt(lo, total) ? total : lo;
        clamped = fp_lt(r, hi) ? r : hi;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dwconv3x3_stride2_pad1_clamp.sv =====
// Throughput: one beat per cycle; the whole pipeline advances while the
// output register is empty or being taken, so a stalled output holds it.
// Reset: coefficients, clamp bounds, left neighbors and valid bits clear to 0.
// ----------------------------------------------------------------------------
// dwconv3x3_stride2_pad1_clamp: 3x3 stride-2 depthwise convolution, binary32
// Three row lanes, a merge/clamp stage, and a per-row left-neighbor store.
// ----------------------------------------------------------------------------
`default_nettype none

module dwconv3x3_stride2_pad1_clamp (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // top_even, top_odd, mid_even, mid_odd, bot_even, bot_odd (low to high)
    input  wire logic [191:0] s_tdata,
    // odd_present
    input  wire logic [0:0]   s_tuser,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_value
    output logic [31:0]       m_tdata,
    output logic              m_tlast
);
    import dwc_pkg::*;

    localparam int Depth = 13;

    logic [63:0] cfg_reg [6];
    fp32_t       left_reg [3];
    fp32_t       ev_reg [3];
    fp32_t       od_reg [3];
    fp32_t       lt_reg [3];
    fp32_t       od_in [3];
    fp32_t       row_sum [3];
    fp32_t       clamped;
    logic        vld_reg [Depth];
    logic        last_reg [Depth];
    logic        m_tvalid_reg;
    logic        m_tlast_reg;
    fp32_t       m_tdata_reg;
    logic        en;
    logic        accept;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            od_in[i] = s_tuser[0] ? s_tdata[64 * i + 32 +: 32] : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                cfg_reg[i] <= 64'd0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_BIAS_K00: cfg_reg[CFG_BIAS_K00] <= cfg_wdata;
                CFG_K01_K02:  cfg_reg[CFG_K01_K02]  <= cfg_wdata;
                CFG_K10_K11:  cfg_reg[CFG_K10_K11]  <= cfg_wdata;
                CFG_K12_K20:  cfg_reg[CFG_K12_K20]  <= cfg_wdata;
                CFG_K21_K22:  cfg_reg[CFG_K21_K22]  <= cfg_wdata;
                CFG_CLAMP:    cfg_reg[CFG_CLAMP]    <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Left taps: previous odd sample of each row, cleared after a row ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                left_reg[i] <= 32'd0;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                left_reg[i] <= s_tlast ? 32'd0 : od_in[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ev_reg[i] <= s_tdata[64 * i +: 32];
                od_reg[i] <= od_in[i];
                lt_reg[i] <= left_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Depth; i++)
            begin
                vld_reg[i]  <= 1'b0;
                last_reg[i] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0]  <= s_tvalid;
            last_reg[0] <= s_tlast;
            for (int i = 1; i < Depth; i++)
            begin
                vld_reg[i]  <= vld_reg[i - 1];
                last_reg[i] <= last_reg[i - 1];
            end
            m_tvalid_reg <= vld_reg[Depth - 1];
            m_tlast_reg  <= last_reg[Depth - 1];
        end
    end

    dwc_lane u_lane_top (
        .clk(clk), .en(en), .has_start(1'b1), .start(cfg_reg[CFG_BIAS_K00][31:0]),
        .ev(ev_reg[0]), .od(od_reg[0]), .lt(lt_reg[0]),
        .kl(cfg_reg[CFG_BIAS_K00][63:32]), .kc(cfg_reg[CFG_K01_K02][31:0]),
        .kr(cfg_reg[CFG_K01_K02][63:32]),
        .row_sum(row_sum[0])
    );

    dwc_lane u_lane_mid (
        .clk(clk), .en(en), .has_start(1'b0), .start(32'd0),
        .ev(ev_reg[1]), .od(od_reg[1]), .lt(lt_reg[1]),
        .kl(cfg_reg[CFG_K10_K11][31:0]), .kc(cfg_reg[CFG_K10_K11][63:32]),
        .kr(cfg_reg[CFG_K12_K20][31:0]),
        .row_sum(row_sum[1])
    );

    dwc_lane u_lane_bot (
        .clk(clk), .en(en), .has_start(1'b0), .start(32'd0),
        .ev(ev_reg[2]), .od(od_reg[2]), .lt(lt_reg[2]),
        .kl(cfg_reg[CFG_K12_K20][63:32]), .kc(cfg_reg[CFG_K21_K22][31:0]),
        .kr(cfg_reg[CFG_K21_K22][63:32]),
        .row_sum(row_sum[2])
    );

    dwc_merge u_merge (
        .clk(clk), .en(en),
        .top(row_sum[0]), .mid(row_sum[1]), .bot(row_sum[2]),
        .lo(cfg_reg[CFG_CLAMP][31:0]), .hi(cfg_reg[CFG_CLAMP][63:32]),
        .clamped(clamped)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= clamped;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for dwconv3x3_stride2_pad1_clamp
// A queue-fed stream driver, a random-stall sink and a scoreboard. The
// scoreboard is fed by a bit-exact binary32 model of the three row lanes,
// the left-neighbor store and the clamp. Several coefficient sets are run.
// ----------------------------------------------------------------------------

module testbench;
    import dwc_pkg::*;

    typedef struct packed {
        logic [191:0] samples;
        logic         odd_present;
        logic         row_end;
    } pair_beat_t;

    typedef struct packed {
        fp32_t value;
        logic  row_end;
    } pixel_t;

    localparam fp32_t POS_INF = 32'h7F80_0000;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tlast;

    pair_beat_t pending_pairs[$];
    pixel_t     expected_pixels[$];
    logic [63:0] coef_regs[6];
    fp32_t      left_taps[3];
    logic       pair_taken;
    int         pairs_sent;
    int         pixels_seen;
    int         row_ends_seen;
    int         mismatches;
    int         stall_mode;

    dwconv3x3_stride2_pad1_clamp uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------- binary32 arithmetic ----------------

    function automatic logic is_nan32(fp32_t v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf32(fp32_t v);
        return (v[30:0] == 31'h7F80_0000);
    endfunction

    // Exact widening; NaN never reaches here
    function automatic real widen(fp32_t v);
        logic [23:0] man;
        int          ex;
        man = {1'b1, v[22:0]};
        ex = int'(v[30:23]) - 127;
        if (v[30:23] == 8'hFF)
        begin
            return $bitstoreal({v[31], 11'h7FF, 52'd0});
        end
        if (v[30:0] == 31'd0)
        begin
            return $bitstoreal({v[31], 63'd0});
        end
        if (v[30:23] == 8'd0)
        begin
            man = {1'b0, v[22:0]};
            ex = -126;
            while (!man[23])
            begin
                man = man << 1;
                ex = ex - 1;
            end
        end
        return $bitstoreal({v[31], 11'(ex + 1023), man[22:0], 29'd0});
    endfunction

    // Round a double to binary32, nearest even, with subnormals
    function automatic fp32_t narrow(real x);
        logic [63:0] b;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] res;
        int          fe;
        int          sh;
        b = $realtobits(x);
        if (b[62:0] == 63'd0)
        begin
            return {b[63], 31'd0};
        end
        fe = int'(b[62:52]) - 1023 + 127;
        if (fe >= 255)
        begin
            return {b[63], POS_INF[30:0]};
        end
        sig = {11'd0, 1'b1, b[51:0]};
        sh = (fe >= 1) ? 29 : 30 - fe;
        if (sh > 60)
        begin
            return {b[63], 31'd0};
        end
        q = sig >> sh;
        rem = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
        begin
            q = q + 64'd1;
        end
        if (fe >= 1)
        begin
            res = (64'(fe) << 23) + q - (64'd1 << 23);
        end
        else
        begin
            res = q;
        end
        if (res >= (64'd255 << 23))
        begin
            return {b[63], POS_INF[30:0]};
        end
        return {b[63], res[30:0]};
    endfunction

    function automatic fp32_t fmul32(fp32_t a, fp32_t b);
        if (is_nan32(a))
        begin
            return a | FP_QUIET_BIT;
        end
        if (is_nan32(b))
        begin
            return b | FP_QUIET_BIT;
        end
        if ((is_inf32(a) && b[30:0] == 31'd0) || (is_inf32(b) && a[30:0] == 31'd0))
        begin
            return FP_DEFAULT_NAN;
        end
        if (is_inf32(a) || is_inf32(b))
        begin
            return {a[31] ^ b[31], POS_INF[30:0]};
        end
        return narrow(widen(a) * widen(b));
    endfunction

    function automatic fp32_t fadd32(fp32_t a, fp32_t b);
        if (is_nan32(a))
        begin
            return a | FP_QUIET_BIT;
        end
        if (is_nan32(b))
        begin
            return b | FP_QUIET_BIT;
        end
        if (is_inf32(a) && is_inf32(b))
        begin
            return (a[31] == b[31]) ? a : FP_DEFAULT_NAN;
        end
        if (is_inf32(a))
        begin
            return a;
        end
        if (is_inf32(b))
        begin
            return b;
        end
        return narrow(widen(a) + widen(b));
    endfunction

    function automatic logic fless32(fp32_t a, fp32_t b);
        if (is_nan32(a) || is_nan32(b))
        begin
            return 1'b0;
        end
        return widen(a) < widen(b);
    endfunction

    // One output pixel; advances the left-neighbor store
    function automatic pixel_t convolve_pair(pair_beat_t p);
        fp32_t  ev[3];
        fp32_t  od[3];
        fp32_t  kl[3];
        fp32_t  kc[3];
        fp32_t  kr[3];
        fp32_t  lane[3];
        fp32_t  acc;
        fp32_t  lo_bound;
        fp32_t  hi_bound;
        pixel_t px;
        kl[0] = coef_regs[CFG_BIAS_K00][63:32];
        kc[0] = coef_regs[CFG_K01_K02][31:0];
        kr[0] = coef_regs[CFG_K01_K02][63:32];
        kl[1] = coef_regs[CFG_K10_K11][31:0];
        kc[1] = coef_regs[CFG_K10_K11][63:32];
        kr[1] = coef_regs[CFG_K12_K20][31:0];
        kl[2] = coef_regs[CFG_K12_K20][63:32];
        kc[2] = coef_regs[CFG_K21_K22][31:0];
        kr[2] = coef_regs[CFG_K21_K22][63:32];
        lo_bound = coef_regs[CFG_CLAMP][31:0];
        hi_bound = coef_regs[CFG_CLAMP][63:32];
        for (int i = 0; i < 3; i++)
        begin
            ev[i] = p.samples[64*i +: 32];
            od[i] = p.odd_present ? p.samples[64*i + 32 +: 32] : 32'd0;
            acc = fmul32(ev[i], kc[i]);
            if (i == 0)
            begin
                acc = fadd32(coef_regs[CFG_BIAS_K00][31:0], acc);
            end
            acc = fadd32(acc, fmul32(od[i], kr[i]));
            lane[i] = fadd32(acc, fmul32(left_taps[i], kl[i]));
        end
        for (int i = 0; i < 3; i++)
        begin
            left_taps[i] = p.row_end ? 32'd0 : od[i];
        end
        acc = fadd32(fadd32(lane[0], lane[1]), lane[2]);
        acc = fless32(lo_bound, acc) ? acc : lo_bound;
        px.value = fless32(acc, hi_bound) ? acc : hi_bound;
        px.row_end = p.row_end;
        return px;
    endfunction

    // ---------------- stimulus ----------------

    function automatic fp32_t random_float(int special_weight);
        logic s;
        s = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) >= special_weight)
        begin
            return {s, 8'($urandom_range(118, 136)), 23'($urandom)};
        end
        case ($urandom_range(0, 4))
            0: return {s, 31'd0};
            1: return {s, POS_INF[30:0]};
            2: return {s, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            3: return {s, 8'd0, 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_pair(logic [191:0] samples, logic odd, logic last);
        pair_beat_t p;
        p.samples = samples;
        p.odd_present = odd;
        p.row_end = last;
        pending_pairs.push_back(p);
        expected_pixels.push_back(convolve_pair(p));
    endtask

    task automatic queue_random_row(int special_weight);
        logic [191:0] samples;
        int           len;
        len = $urandom_range(1, 7);
        for (int j = 0; j < len; j++)
        begin
            for (int w = 0; w < 6; w++)
            begin
                samples[32*w +: 32] = random_float(special_weight);
            end
            // drop the odd column mostly at the row's end
            queue_pair(samples,
                       (j == len - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) != 0),
                       (j == len - 1) || ($urandom_range(0, 29) == 0));
        end
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        coef_regs[idx] = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_random_coefs(int special_weight, logic wide_clamp);
        for (int r = CFG_BIAS_K00; r <= CFG_K21_K22; r++)
        begin
            write_reg(cfg_idx_t'(r), {random_float(special_weight), random_float(special_weight)});
        end
        if (wide_clamp)
        begin
            write_reg(CFG_CLAMP, {POS_INF, 1'b1, POS_INF[30:0]});
        end
        else
        begin
            write_reg(CFG_CLAMP, {random_float(special_weight), random_float(special_weight)});
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR pixel %0d %s: got %h expected %h", pixels_seen, what, got, want);
        mismatches++;
    endtask

    // ---------------- driver and sink ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_taken <= 1'b0;
        end
        else
        begin
            pair_taken <= s_tvalid && s_tready;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pair_taken)
            begin
                void'(pending_pairs.pop_front());
                pairs_sent++;
            end
            stall_mode = (pairs_sent < 260) ? 0 : (pairs_sent < 520) ? 1 : 2;
            if (s_tvalid && !pair_taken)
            begin
                // hold the offered beat
            end
            else if (pending_pairs.size() != 0 &&
                     $urandom_range(0, 99) >= ((stall_mode == 0) ? 34 : (stall_mode == 1) ? 82 : 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_pairs[0].samples;
                s_tuser <= pending_pairs[0].odd_present;
                s_tlast <= pending_pairs[0].row_end;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
            m_tready <= $urandom_range(0, 99) >=
                        ((stall_mode == 0) ? 82 : (stall_mode == 1) ? 34 : 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                report("unexpected beat", m_tdata, 32'd0);
            end
            else
            begin
                if (m_tdata !== expected_pixels[0].value)
                begin
                    report("value", m_tdata, expected_pixels[0].value);
                end
                if (m_tlast !== expected_pixels[0].row_end)
                begin
                    report("row end", {31'd0, m_tlast}, {31'd0, expected_pixels[0].row_end});
                end
                void'(expected_pixels.pop_front());
            end
            pixels_seen++;
            row_ends_seen += int'(m_tlast);
        end
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_BIAS_K00;
        cfg_wdata = 64'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        pairs_sent = 0;
        pixels_seen = 0;
        row_ends_seen = 0;
        mismatches = 0;
        for (int i = 0; i < 6; i++)
        begin
            coef_regs[i] = 64'd0;
        end
        for (int i = 0; i < 3; i++)
        begin
            left_taps[i] = 32'd0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset coefficients: every pixel clamps to zero
        queue_pair({6{32'h3F80_0000}}, 1'b1, 1'b0);
        queue_pair({6{32'hBF80_0000}}, 1'b1, 1'b1);
        wait_drained();

        // simple weights, open clamp: extremes and special values
        write_reg(CFG_BIAS_K00, {32'h3F80_0000, 32'h3F00_0000});
        write_reg(CFG_K01_K02, {32'h4000_0000, 32'hBF80_0000});
        write_reg(CFG_K10_K11, {32'h3E80_0000, 32'h4040_0000});
        write_reg(CFG_K12_K20, {32'hC000_0000, 32'h3F40_0000});
        write_reg(CFG_K21_K22, {32'h3F80_0000, 32'h3DCC_CCCD});
        write_reg(CFG_CLAMP, {POS_INF, 1'b1, POS_INF[30:0]});
        queue_pair({6{32'h0000_0000}}, 1'b1, 1'b0);
        queue_pair({6{32'hFFFF_FFFF}}, 1'b1, 1'b0);
        queue_pair({6{32'h3F80_0000}}, 1'b1, 1'b0);
        queue_pair({6{32'h4000_0000}}, 1'b0, 1'b0);
        queue_pair({6{32'h4040_0000}}, 1'b1, 1'b1);
        queue_pair({6{32'h7F80_0000}}, 1'b1, 1'b0);
        queue_pair({6{32'hFF80_0000}}, 1'b1, 1'b1);
        queue_pair({6{32'h0000_0001}}, 1'b1, 1'b0);
        queue_pair({6{32'h807F_FFFF}}, 1'b1, 1'b1);
        queue_pair({6{32'h7F7F_FFFF}}, 1'b1, 1'b0);
        queue_pair({6{32'hFF7F_FFFF}}, 1'b0, 1'b1);
        queue_pair({6{32'h7FC0_0001}}, 1'b1, 1'b1);
        queue_pair({32'h4100_0000, 32'h3F80_0000, 32'hC000_0000, 32'h7F80_0000,
                    32'h4000_0000, 32'hFF80_0000}, 1'b1, 1'b0);
        queue_pair({6{32'h5555_5555}}, 1'b1, 1'b0);
        queue_pair({6{32'hAAAA_AAAA}}, 1'b1, 1'b1);
        wait_drained();

        // narrow clamp, then NaN upper bound
        write_reg(CFG_CLAMP, {32'h3F80_0000, 32'hBF80_0000});
        queue_pair({6{32'h4000_0000}}, 1'b1, 1'b0);
        queue_pair({6{32'hC000_0000}}, 1'b1, 1'b0);
        queue_pair({6{32'h7FC0_0000}}, 1'b1, 1'b1);
        wait_drained();
        write_reg(CFG_CLAMP, {32'h7FC1_2345, 32'hFF80_0000});
        queue_pair({6{32'h3F80_0000}}, 1'b1, 1'b1);
        queue_pair({6{32'h0000_0000}}, 1'b0, 1'b1);
        wait_drained();

        // all ones in every register
        for (int r = CFG_BIAS_K00; r <= CFG_CLAMP; r++)
        begin
            write_reg(cfg_idx_t'(r), 64'hFFFF_FFFF_FFFF_FFFF);
        end
        queue_pair({6{32'h3F80_0000}}, 1'b1, 1'b1);
        wait_drained();

        // random rows over several coefficient sets
        for (int ph = 0; ph < 6; ph++)
        begin
            write_random_coefs((ph == 5) ? 40 : 5, ph < 2);
            for (int n = 0; n < 30; n++)
            begin
                queue_random_row((ph >= 4) ? 25 : 4);
                // let the sender sit out until the pipeline empties
                if (n == 15 && ph == 1)
                begin
                    while (pending_pairs.size() != 0 || expected_pixels.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
            end
            wait_drained();
        end

        $display("Covered %0d input pairs, %0d pixels, %0d row ends, over 11 register settings.",
                 pairs_sent, pixels_seen, row_ends_seen);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== dwconv3x3_stride2_pad1_clamp.f =====
hw/rtl/dwc_pkg.sv
hw/rtl/dwc_fmul.sv
hw/rtl/dwc_fadd.sv
hw/rtl/dwc_lane.sv
hw/rtl/dwc_merge.sv
hw/rtl/dwconv3x3_stride2_pad1_clamp.sv
test/testbench.sv
